/* hw/rtl/strided_layout_offset_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the strided layout offset core
// Shared concurrent assertion forms; they are empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef STRIDED_LAYOUT_OFFSET_CORE_ASSERT_SVH
`define STRIDED_LAYOUT_OFFSET_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define SLO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SLO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SLO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SLO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/slo_pkg.sv */
// ----------------------------------------------------------------------------
// Strided layout offset package
// Shared widths, codes and the word that travels down the divider pipeline.
// ----------------------------------------------------------------------------
package slo_pkg;

    localparam int SLO_MODES      = 4;
    localparam int SLO_KEY_W      = 48;
    localparam int SLO_EXT_W      = 16;
    localparam int SLO_STEP_W     = 32;
    localparam int SLO_COORD_W    = 17;
    localparam int SLO_OFS_W      = 64;
    localparam int SLO_STAGE_BITS = 4;
    localparam int SLO_DIV_STAGES = SLO_KEY_W / SLO_STAGE_BITS;
    localparam int SLO_PROD_W     = SLO_STEP_W + SLO_COORD_W;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_KEY   = 2'd1;
    localparam logic [1:0] ERR_COORD = 2'd2;

    localparam logic [2:0] CFG_SIZE0 = 3'd0;
    localparam logic [2:0] CFG_SIZE1 = 3'd1;
    localparam logic [2:0] CFG_SIZE2 = 3'd2;
    localparam logic [2:0] CFG_SIZE3 = 3'd3;
    localparam logic [2:0] CFG_STEP0 = 3'd4;
    localparam logic [2:0] CFG_STEP1 = 3'd5;
    localparam logic [2:0] CFG_STEP2 = 3'd6;
    localparam logic [2:0] CFG_STEP3 = 3'd7;

    typedef logic [SLO_MODES-1:0][SLO_EXT_W-1:0]  t_slo_ext;
    typedef logic [SLO_MODES-1:0][SLO_STEP_W-1:0] t_slo_step;

    typedef struct packed {
        logic                                   valid;
        logic                                   mode;
        logic                                   neg;
        logic [2:0]                             cnt;
        logic [SLO_MODES-1:0][SLO_COORD_W-1:0]  coord;
        logic [SLO_KEY_W-1:0]                   work;
        logic [SLO_EXT_W-1:0]                   rem;
        logic [SLO_MODES-1:0][SLO_EXT_W-1:0]    res;
    } t_slo_item;

endpackage

/* hw/rtl/slo_div_stage.sv */
// ----------------------------------------------------------------------------
// Divider pipeline stage
// Four restoring division steps of the magnitude key by one mode's extent.
// ----------------------------------------------------------------------------
module slo_div_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [slo_pkg::SLO_EXT_W-1:0]     i_ext,
    input  logic [1:0]                        i_slot,
    input  logic                              i_last,
    input  slo_pkg::t_slo_item                i_item,
    output slo_pkg::t_slo_item                o_item
);

    slo_pkg::t_slo_item r_item;
    slo_pkg::t_slo_item n_item;

    always_comb begin
        logic [slo_pkg::SLO_EXT_W:0] v_trial;
        logic                        v_ge;
        n_item = i_item;
        for (int j = 0; j < slo_pkg::SLO_STAGE_BITS; j++) begin
            v_trial     = {n_item.rem, n_item.work[slo_pkg::SLO_KEY_W-1]};
            v_ge        = (v_trial >= {1'b0, i_ext});
            n_item.work = {n_item.work[slo_pkg::SLO_KEY_W-2:0], v_ge};
            if (v_ge) begin
                v_trial = v_trial - {1'b0, i_ext};
            end
            n_item.rem  = v_trial[slo_pkg::SLO_EXT_W-1:0];
        end
        // At the end of a mode the remainder is parked and the quotient
        // left in work becomes the dividend of the next mode.
        if (i_last) begin
            n_item.res[i_slot] = n_item.rem;
            n_item.rem         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

/* hw/rtl/slo_mac.sv */
// ----------------------------------------------------------------------------
// Offset accumulate stages
// Forms coordinates and errors, multiplies by strides and sums the terms.
// ----------------------------------------------------------------------------
`include "strided_layout_offset_core_assert.svh"

module slo_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slo_pkg::t_slo_ext                 i_ext,
    input  slo_pkg::t_slo_step                i_step,
    input  slo_pkg::t_slo_item                i_item,
    output logic                              o_done,
    output logic [slo_pkg::SLO_OFS_W-1:0]     o_offset,
    output logic [1:0]                        o_error_code
);

    typedef logic [slo_pkg::SLO_MODES-1:0][slo_pkg::SLO_COORD_W-1:0] t_ops;
    typedef logic [slo_pkg::SLO_MODES-1:0][slo_pkg::SLO_PROD_W-1:0]  t_prods;

    logic                           r_valid_a, r_valid_b, r_valid_c;
    logic [1:0]                     r_err_a, r_err_b, r_err_c;
    t_ops                           r_ops_a;
    t_prods                         r_prod_b;
    logic [slo_pkg::SLO_OFS_W-1:0]  r_sum01_c, r_sum23_c;
    logic                           r_done;
    logic [slo_pkg::SLO_OFS_W-1:0]  r_offset;
    logic [1:0]                     r_err;

    t_ops                           n_ops;
    logic [1:0]                     n_err;

    // Operand and error selection.
    always_comb begin
        logic [2:0]                    v_cnt;
        logic [slo_pkg::SLO_EXT_W-1:0] v_r;
        logic                          v_bad;
        v_cnt = (i_item.cnt > 3'(slo_pkg::SLO_MODES)) ? 3'(slo_pkg::SLO_MODES) : i_item.cnt;
        v_bad = 1'b0;
        for (int i = 0; i < slo_pkg::SLO_MODES; i++) begin
            v_r = i_item.neg ? (i_ext[i] - 16'd1 - i_item.res[i]) : i_item.res[i];
            if (!i_item.mode) begin
                n_ops[i] = {1'b0, v_r};
            end else if (3'(i) < v_cnt) begin
                n_ops[i] = i_item.coord[i];
                if ($signed({i_item.coord[i][slo_pkg::SLO_COORD_W-1], i_item.coord[i]})
                    >= $signed({2'b00, i_ext[i]})) begin
                    v_bad = 1'b1;
                end
            end else begin
                n_ops[i] = '0;
            end
        end
        if (!i_item.mode) begin
            n_err = (!i_item.neg && (i_item.work != '0)) ? slo_pkg::ERR_KEY : slo_pkg::ERR_OK;
        end else begin
            n_err = v_bad ? slo_pkg::ERR_COORD : slo_pkg::ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ops_a  <= n_ops;
        r_err_a  <= n_err;
        for (int i = 0; i < slo_pkg::SLO_MODES; i++) begin
            r_prod_b[i] <= slo_pkg::SLO_PROD_W'($signed(i_step[i]) * $signed(r_ops_a[i]));
        end
        r_err_b   <= r_err_a;
        r_sum01_c <= slo_pkg::SLO_OFS_W'($signed(r_prod_b[0]))
                   + slo_pkg::SLO_OFS_W'($signed(r_prod_b[1]));
        r_sum23_c <= slo_pkg::SLO_OFS_W'($signed(r_prod_b[2]))
                   + slo_pkg::SLO_OFS_W'($signed(r_prod_b[3]));
        r_err_c   <= r_err_b;
        r_offset  <= (r_err_c == slo_pkg::ERR_OK) ? (r_sum01_c + r_sum23_c) : '0;
        r_err     <= r_err_c;
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_valid_a <= i_item.valid;
            r_valid_b <= r_valid_a;
            r_valid_c <= r_valid_b;
            r_done    <= r_valid_c;
        end
    end

    assign o_done       = r_done;
    assign o_offset     = r_offset;
    assign o_error_code = r_err;

    `SLO_ASSERT_NEXT(a_valid_flow, i_clk, i_rst_n, r_valid_a, r_valid_b)
    `SLO_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_done && (r_err != slo_pkg::ERR_OK), r_offset == '0)
    `SLO_ASSERT_NEXT(a_err_carry, i_clk, i_rst_n, r_valid_c, r_err == $past(r_err_c))

endmodule

/* hw/rtl/strided_layout_offset_core.sv */
// ----------------------------------------------------------------------------
// Strided layout offset core
// Maps a linear key or explicit coordinates to a memory offset.
// ----------------------------------------------------------------------------
// A word is taken in every cycle in which i_start is high; o_busy is always
// low, so the core never refuses a word. Each word produces exactly one
// result, shown for one cycle with o_done, in the order the words came in.
// The pipeline has one input register, 48 divider stages
// (twelve per mode, four quotient bits each, which set the depth) and four
// stages that form the coordinates, multiply by the strides, sum and register
// the result. The receiver cannot hold results off and none is needed, as
// the pipeline never stalls. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data and must only change while no word is in flight.
// A negative key is decomposed with floored remainders; it is split into
// its one's complement magnitude, divided unsigned and mapped back.
module strided_layout_offset_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_mode,
    input  logic [slo_pkg::SLO_KEY_W-1:0]       i_linear_key,
    input  logic [slo_pkg::SLO_COORD_W-1:0]     i_coord_a,
    input  logic [slo_pkg::SLO_COORD_W-1:0]     i_coord_b,
    input  logic [slo_pkg::SLO_COORD_W-1:0]     i_coord_c,
    input  logic [slo_pkg::SLO_COORD_W-1:0]     i_coord_d,
    input  logic [2:0]                          i_coord_count,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_index,
    input  logic [slo_pkg::SLO_STEP_W-1:0]      i_cfg_data,
    output logic                                o_done,
    output logic [slo_pkg::SLO_OFS_W-1:0]       o_offset,
    output logic [1:0]                          o_error_code
);

    slo_pkg::t_slo_ext   r_size;
    slo_pkg::t_slo_step  r_step;
    slo_pkg::t_slo_ext   w_ext;
    slo_pkg::t_slo_item  r_in;
    slo_pkg::t_slo_item  n_in;
    slo_pkg::t_slo_item  w_chain [slo_pkg::SLO_DIV_STAGES*slo_pkg::SLO_MODES+1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < slo_pkg::SLO_MODES; i++) begin
                r_size[i] <= 16'd1;
                r_step[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slo_pkg::CFG_SIZE0: r_size[0] <= i_cfg_data[15:0];
                slo_pkg::CFG_SIZE1: r_size[1] <= i_cfg_data[15:0];
                slo_pkg::CFG_SIZE2: r_size[2] <= i_cfg_data[15:0];
                slo_pkg::CFG_SIZE3: r_size[3] <= i_cfg_data[15:0];
                slo_pkg::CFG_STEP0: r_step[0] <= i_cfg_data;
                slo_pkg::CFG_STEP1: r_step[1] <= i_cfg_data;
                slo_pkg::CFG_STEP2: r_step[2] <= i_cfg_data;
                slo_pkg::CFG_STEP3: r_step[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // An extent written as zero behaves as one everywhere.
    always_comb begin
        for (int i = 0; i < slo_pkg::SLO_MODES; i++) begin
            w_ext[i] = (r_size[i] == '0) ? 16'd1 : r_size[i];
        end
    end

    // Input register: the key is reduced to a non-negative magnitude.
    always_comb begin
        n_in        = '0;
        n_in.valid  = i_start;
        n_in.mode   = i_mode;
        n_in.neg    = i_linear_key[slo_pkg::SLO_KEY_W-1];
        n_in.cnt    = i_coord_count;
        n_in.coord  = {i_coord_d, i_coord_c, i_coord_b, i_coord_a};
        n_in.work   = n_in.neg ? ~i_linear_key : i_linear_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else begin
            r_in <= n_in;
        end
    end

    assign w_chain[0] = r_in;

    for (genvar s = 0; s < slo_pkg::SLO_DIV_STAGES*slo_pkg::SLO_MODES; s++) begin : g_div
        slo_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ext   (w_ext[s / slo_pkg::SLO_DIV_STAGES]),
            .i_slot  (2'(s / slo_pkg::SLO_DIV_STAGES)),
            .i_last  ((s % slo_pkg::SLO_DIV_STAGES) == (slo_pkg::SLO_DIV_STAGES - 1)),
            .i_item  (w_chain[s]),
            .o_item  (w_chain[s+1])
        );
    end

    slo_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ext        (w_ext),
        .i_step       (r_step),
        .i_item       (w_chain[slo_pkg::SLO_DIV_STAGES*slo_pkg::SLO_MODES]),
        .o_done       (o_done),
        .o_offset     (o_offset),
        .o_error_code (o_error_code)
    );

    assign o_busy = 1'b0;

endmodule
